// File: rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants for the segment intersection test.
// Holds the word structs, the widths of all intermediate values and the
// front-to-back record type.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 16;
  localparam int OutBits   = 32;

  // Differences need one more bit than the coordinates; products twice that plus one.
  localparam int DiffBits = CoordBits + 1;
  localparam int ProdBits = 2 * DiffBits + 1;
  // Numerator: c (ProdBits) times d (DiffBits), difference of two such terms.
  localparam int NumBits  = ProdBits + DiffBits + 1;
  // Dividend magnitude after the fractional shift.
  localparam int DvdBits  = NumBits + FracBits;
  localparam int DenBits  = ProdBits;
  localparam int QDepth   = 4;
  localparam int QPtrBits = $clog2(QDepth);

  typedef struct packed {
    logic signed [CoordBits-1:0] a_now_x;
    logic signed [CoordBits-1:0] a_now_y;
    logic signed [CoordBits-1:0] a_prev_x;
    logic signed [CoordBits-1:0] a_prev_y;
    logic signed [CoordBits-1:0] b_now_x;
    logic signed [CoordBits-1:0] b_now_y;
    logic signed [CoordBits-1:0] b_prev_x;
    logic signed [CoordBits-1:0] b_prev_y;
  } seg_in_t;

  typedef struct packed {
    logic                      hit;
    logic                      parallel;
    logic signed [OutBits-1:0] meet_x;
    logic signed [OutBits-1:0] meet_y;
  } seg_out_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic                      hit;
    logic                      parallel;
    logic                      neg_x;
    logic                      neg_y;
    logic [DvdBits-1:0]        dvd_x;
    logic [DvdBits-1:0]        dvd_y;
    logic [DenBits-1:0]        den;
  } seg_job_t;

endpackage

// File: rtl/sit_front.sv
// ----------------------------------------------------------------------------
// sit_front: orientation tests and line numerators.
// Three register stages: differences, products, then hit rule and numerators.
// ----------------------------------------------------------------------------
module sit_front
  import sit_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  seg_in_t  in_word_i,
  output logic     job_valid_o,
  output seg_job_t job_o
);

  typedef logic signed [DiffBits-1:0] diff_t;
  typedef logic signed [ProdBits-1:0] prod_t;
  typedef logic signed [NumBits-1:0]  num_t;

  // Stage 1: differences and the raw endpoints needed for cA, cB.
  logic [2:0] vld_q;
  diff_t ux1_q, uy1_q, ux2_q, uy2_q, vx1_q, vy1_q, vx2_q, vy2_q;
  diff_t dax_q, day_q, dbx_q, dby_q;
  diff_t anx_q, any_q, apx_q, apy_q, bnx_q, bny_q, bpx_q, bpy_q;

  function automatic diff_t sx(input logic signed [CoordBits-1:0] v);
    sx = diff_t'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // s = ccw(An,Ap,B*) uses u = An - B*, v = Ap - B*.
    ux1_q <= sx(in_word_i.a_now_x) - sx(in_word_i.b_now_x);
    uy1_q <= sx(in_word_i.a_now_y) - sx(in_word_i.b_now_y);
    vx1_q <= sx(in_word_i.a_prev_x) - sx(in_word_i.b_now_x);
    vy1_q <= sx(in_word_i.a_prev_y) - sx(in_word_i.b_now_y);
    ux2_q <= sx(in_word_i.a_now_x) - sx(in_word_i.b_prev_x);
    uy2_q <= sx(in_word_i.a_now_y) - sx(in_word_i.b_prev_y);
    vx2_q <= sx(in_word_i.a_prev_x) - sx(in_word_i.b_prev_x);
    vy2_q <= sx(in_word_i.a_prev_y) - sx(in_word_i.b_prev_y);
    dax_q <= sx(in_word_i.a_now_x) - sx(in_word_i.a_prev_x);
    day_q <= sx(in_word_i.a_now_y) - sx(in_word_i.a_prev_y);
    dbx_q <= sx(in_word_i.b_now_x) - sx(in_word_i.b_prev_x);
    dby_q <= sx(in_word_i.b_now_y) - sx(in_word_i.b_prev_y);
    anx_q <= sx(in_word_i.a_now_x);
    any_q <= sx(in_word_i.a_now_y);
    apx_q <= sx(in_word_i.a_prev_x);
    apy_q <= sx(in_word_i.a_prev_y);
    bnx_q <= sx(in_word_i.b_now_x);
    bny_q <= sx(in_word_i.b_now_y);
    bpx_q <= sx(in_word_i.b_prev_x);
    bpy_q <= sx(in_word_i.b_prev_y);
  end

  // Stage 2: one product per term, then differences.
  // t = ccw(Bn,Bp,A*) = cross(Bn-A*, Bp-A*); for A* = An this is cross(-u1, -u2)
  // = cross(u1, u2), and for A* = Ap cross(v1, v2), so it reuses stage 1 differences.
  prod_t s1_q, s2_q, t1_q, t2_q, det_q, ca_q, cb_q;
  diff_t dax2_q, day2_q, dbx2_q, dby2_q;

  function automatic prod_t mul(input diff_t a, input diff_t b);
    mul = prod_t'(a) * prod_t'(b);
  endfunction

  always_ff @(posedge clk_i) begin
    s1_q <= mul(ux1_q, vy1_q) - mul(uy1_q, vx1_q);
    s2_q <= mul(ux2_q, vy2_q) - mul(uy2_q, vx2_q);
    // t1: p=Bn, q=Bp, r=An -> (Bn-An) x (Bp-An) = (-ux1) x (-ux2 style):
    // Bn-An = -ux1, Bp-An = -ux2; cross(-ux1,-ux2) = cross(ux1,ux2).
    t1_q <= mul(ux1_q, uy2_q) - mul(uy1_q, ux2_q);
    t2_q <= mul(vx1_q, vy2_q) - mul(vy1_q, vx2_q);
    det_q <= mul(dax_q, dby_q) - mul(day_q, dbx_q);
    ca_q  <= mul(anx_q, apy_q) - mul(any_q, apx_q);
    cb_q  <= mul(bnx_q, bpy_q) - mul(bny_q, bpx_q);
    dax2_q <= dax_q;
    day2_q <= day_q;
    dbx2_q <= dbx_q;
    dby2_q <= dby_q;
  end

  // Stage 3: hit rule, numerators, signs and magnitudes.
  function automatic logic [1:0] sgn(input prod_t v);
    // {neg, zero}
    sgn = {v[ProdBits-1], v == '0};
  endfunction

  function automatic num_t nmul(input prod_t c, input diff_t d);
    nmul = num_t'(c) * num_t'(d);
  endfunction

  logic [1:0] g1, g2, g3, g4;
  logic p_neg, p_zero, q_neg, q_zero, hit;
  num_t nx, ny;

  always_comb begin
    g1 = sgn(s1_q);
    g2 = sgn(s2_q);
    g3 = sgn(t1_q);
    g4 = sgn(t2_q);
    p_zero = g1[0] | g2[0];
    p_neg  = !p_zero && (g1[1] != g2[1]);
    q_zero = g3[0] | g4[0];
    q_neg  = !q_zero && (g3[1] != g4[1]);
    hit    = (p_neg && (q_neg || q_zero)) || (p_zero && q_neg);
    nx     = nmul(ca_q, dbx2_q) - nmul(cb_q, dax2_q);
    ny     = nmul(ca_q, dby2_q) - nmul(cb_q, day2_q);
  end

  always_ff @(posedge clk_i) begin
    job_o.hit      <= hit;
    job_o.parallel <= det_q == '0;
    job_o.neg_x    <= nx[NumBits-1] ^ det_q[ProdBits-1];
    job_o.neg_y    <= ny[NumBits-1] ^ det_q[ProdBits-1];
    job_o.dvd_x    <= DvdBits'(nx[NumBits-1] ? -nx : nx) << FracBits;
    job_o.dvd_y    <= DvdBits'(ny[NumBits-1] ? -ny : ny) << FracBits;
    job_o.den      <= det_q[ProdBits-1] ? DenBits'(-det_q) : DenBits'(det_q);
  end

  assign job_valid_o = vld_q[2];

endmodule

// File: rtl/sit_queue.sv
// ----------------------------------------------------------------------------
// sit_queue: short FIFO between the front and the divider back end.
// Registers hold the entries; the back pops one per cycle when not empty.
// ----------------------------------------------------------------------------
module sit_queue
  import sit_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  seg_job_t push_word_i,
  input  logic     pop_i,
  output logic     empty_o,
  output seg_job_t head_o
);

  seg_job_t           mem_q [QDepth];
  logic [QPtrBits-1:0] wr_q, rd_q;
  logic [QPtrBits:0]   cnt_q;

  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPtrBits+1)'(push_i) - (QPtrBits+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_word_i;
  end

endmodule

// File: rtl/sit_back.sv
// ----------------------------------------------------------------------------
// sit_back: pipelined restoring dividers for the meeting point, one quotient
// bit per stage, with truncation toward zero and 32-bit saturation.
// ----------------------------------------------------------------------------
module sit_back
  import sit_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  seg_job_t job_i,
  output logic     res_valid_o,
  output seg_out_t res_o
);

  localparam int Stages = DvdBits;
  localparam int RemBits = DenBits + 1;

  typedef struct packed {
    logic               hit;
    logic               parallel;
    logic               neg_x;
    logic               neg_y;
    logic [DenBits-1:0] den;
    logic [DvdBits-1:0] nx;   // dividend bits still to shift in, then quotient
    logic [DvdBits-1:0] ny;
    logic [RemBits-1:0] rx;
    logic [RemBits-1:0] ry;
  } stg_t;

  stg_t       stg_q [Stages+1];
  logic [Stages:0] vld_q;

  assign stg_q[0] = '{hit:      job_i.hit,
                      parallel: job_i.parallel,
                      neg_x:    job_i.neg_x,
                      neg_y:    job_i.neg_y,
                      den:      job_i.den,
                      nx:       job_i.dvd_x,
                      ny:       job_i.dvd_y,
                      rx:       '0,
                      ry:       '0};

  assign vld_q[0] = job_valid_i;

  function automatic logic [RemBits+DvdBits-1:0] step(input logic [RemBits-1:0] r,
                                                      input logic [DvdBits-1:0] n,
                                                      input logic [DenBits-1:0] d);
    logic [RemBits-1:0] t;
    logic [DvdBits-1:0] q;
    t = {r[RemBits-2:0], n[DvdBits-1]};
    q = {n[DvdBits-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      q[0] = 1'b1;
    end
    step = {t, q};
  endfunction

  for (genvar i = 0; i < Stages; i++) begin : g_div
    logic v_q;
    stg_t s_d, s_q;
    always_comb begin
      s_d = stg_q[i];
      {s_d.rx, s_d.nx} = step(stg_q[i].rx, stg_q[i].nx, stg_q[i].den);
      {s_d.ry, s_d.ny} = step(stg_q[i].ry, stg_q[i].ny, stg_q[i].den);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      s_q <= s_d;
    end
    assign vld_q[i+1] = v_q;
    assign stg_q[i+1] = s_q;
  end

  function automatic logic [OutBits-1:0] sat(input logic [DvdBits-1:0] q, input logic neg);
    if (neg) begin
      if (q > DvdBits'(64'h8000_0000)) sat = 32'h8000_0000;
      else sat = OutBits'(-q);
    end else begin
      if (q > DvdBits'(64'h7FFF_FFFF)) sat = 32'h7FFF_FFFF;
      else sat = OutBits'(q);
    end
  endfunction

  stg_t last;
  assign last = stg_q[Stages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= vld_q[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.hit      <= last.hit;
    res_o.parallel <= last.parallel;
    res_o.meet_x   <= last.parallel ? '0 : sat(last.nx, last.neg_x);
    res_o.meet_y   <= last.parallel ? '0 : sat(last.ny, last.neg_y);
  end

endmodule

// File: rtl/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// segment_intersection_test: orientation-rule segment crossing test with the
// line-line meeting point in signed Q16.16.
//
//   channel | ports                        | handshake
//   --------+------------------------------+--------------------------------
//   input   | start_i, busy_o, seg_i       | taken when start_i && !busy_o
//   result  | done_o, res_o                | one-cycle strobe, no back-pressure
//
// One word is taken every cycle. The path runs through three front stages,
// the queue registers, one divider stage per dividend bit (69), and one
// output register. busy_o stays low; the queue only absorbs skew between
// front and back.
// Reset is asynchronous and clears every valid flag.
// ----------------------------------------------------------------------------
module segment_intersection_test
  import sit_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  seg_in_t  seg_i,
  output logic     done_o,
  output seg_out_t res_o
);

  logic     job_valid, empty, pop;
  seg_job_t job, head;

  // The back end never stalls, so the queue pops whenever it holds an entry.
  assign busy_o = 1'b0;

  sit_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start_i && !busy_o),
    .in_word_i   (seg_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  sit_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_valid),
    .push_word_i (job),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  assign pop = !empty;

  sit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop),
    .job_i       (head),
    .res_valid_o (done_o),
    .res_o       (res_o)
  );

endmodule
